// ===== hw/rtl/raf_pkg.sv =====
// Shared types, constants and helpers for the register ALU with flags.
package raf_pkg;

    // Register file geometry
    localparam int NUM_REGS  = 8;
    localparam int REG_IDX_W = 3;
    localparam int RF_AW     = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int DATA_W    = 32;
    localparam int SHAMT_W   = 8;

    typedef enum logic [3:0] {
        CMD_ADD  = 4'd0,
        CMD_SUB  = 4'd1,
        CMD_MVN  = 4'd2,
        CMD_AND  = 4'd3,
        CMD_ORR  = 4'd4,
        CMD_EOR  = 4'd5,
        CMD_LSL  = 4'd6,
        CMD_LSR  = 4'd7,
        CMD_ASR  = 4'd8,
        CMD_ADDS = 4'd9,
        CMD_SUBS = 4'd10,
        CMD_ANDS = 4'd11,
        CMD_EORS = 4'd12,
        CMD_MVNS = 4'd13,
        CMD_ORRS = 4'd14,
        CMD_MOV  = 4'd15
    } cmd_t;

    typedef struct packed {
        cmd_t                   cmd;
        logic [REG_IDX_W-1:0]   dest_reg;
        logic                   first_is_imm;
        logic [REG_IDX_W-1:0]   first_reg;
        logic [DATA_W-1:0]      first_imm;
        logic                   second_is_imm;
        logic [REG_IDX_W-1:0]   second_reg;
        logic [DATA_W-1:0]      second_imm;
    } req_beat_t;

    typedef struct packed {
        logic [DATA_W-1:0] written_value;
        logic              flag_neg;
        logic              flag_zero;
        logic              flag_carry;
        logic              flag_over;
    } rsp_beat_t;

    typedef struct packed {
        logic n;
        logic z;
        logic c;
        logic v;
    } flags_t;

    // Register file read request, issued on the beat that accepts an instruction
    typedef struct packed {
        logic                 en;
        logic [REG_IDX_W-1:0] addr_a;
        logic [REG_IDX_W-1:0] addr_b;
    } rf_rd_t;

    // Register file write, issued when an instruction retires
    typedef struct packed {
        logic                 en;
        logic [REG_IDX_W-1:0] addr;
        logic [DATA_W-1:0]    data;
    } rf_wr_t;

    function automatic logic reg_in_range(input logic [REG_IDX_W-1:0] idx);
        return int'(idx) < NUM_REGS;
    endfunction

endpackage

// ===== hw/rtl/raf_regfile.sv =====
// Register file: synchronous memory with two read ports, valid bits and write forwarding.
module raf_regfile
    import raf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  rf_rd_t            rd,
    input  rf_wr_t            wr,
    output logic [DATA_W-1:0] rd_data_a,
    output logic [DATA_W-1:0] rd_data_b
);

    logic [DATA_W-1:0]   mem [NUM_REGS];
    logic [NUM_REGS-1:0] vld_reg;

    logic [DATA_W-1:0] raw_a_reg;
    logic [DATA_W-1:0] raw_b_reg;
    logic              use_a_reg;
    logic              use_b_reg;
    logic              hit_a_reg;
    logic              hit_b_reg;
    logic [DATA_W-1:0] fwd_reg;

    logic wr_ok;
    logic rd_ok_a;
    logic rd_ok_b;

    assign wr_ok   = wr.en && reg_in_range(wr.addr);
    assign rd_ok_a = reg_in_range(rd.addr_a);
    assign rd_ok_b = reg_in_range(rd.addr_b);

    // Storage: write on retire, read on accept
    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            mem[RF_AW'(wr.addr)] <= wr.data;
        end
        if (rd.en)
        begin
            if (rd_ok_a)
            begin
                raw_a_reg <= mem[RF_AW'(rd.addr_a)];
            end
            if (rd_ok_b)
            begin
                raw_b_reg <= mem[RF_AW'(rd.addr_b)];
            end
            fwd_reg <= wr.data;
        end
    end

    // Entry valid bits and read qualifiers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            use_a_reg <= 1'b0;
            use_b_reg <= 1'b0;
            hit_a_reg <= 1'b0;
            hit_b_reg <= 1'b0;
        end
        else
        begin
            if (wr_ok)
            begin
                vld_reg[RF_AW'(wr.addr)] <= 1'b1;
            end
            if (rd.en)
            begin
                use_a_reg <= rd_ok_a && vld_reg[RF_AW'(rd.addr_a)];
                use_b_reg <= rd_ok_b && vld_reg[RF_AW'(rd.addr_b)];
                // same-edge write is not seen by the read; bypass it
                hit_a_reg <= wr_ok && (wr.addr == rd.addr_a);
                hit_b_reg <= wr_ok && (wr.addr == rd.addr_b);
            end
        end
    end

    always_comb
    begin
        rd_data_a = hit_a_reg ? fwd_reg : (use_a_reg ? raw_a_reg : '0);
        rd_data_b = hit_b_reg ? fwd_reg : (use_b_reg ? raw_b_reg : '0);
    end

endmodule

// ===== hw/rtl/raf_alu.sv =====
// Execute unit: adder, barrel shifter, logic ops and NZCV update.
module raf_alu
    import raf_pkg::*;
(
    input  cmd_t              op,
    input  logic [DATA_W-1:0] a,
    input  logic [DATA_W-1:0] b,
    input  flags_t            flags_in,
    output logic [DATA_W-1:0] result,
    output flags_t            flags_out
);

    logic [SHAMT_W-1:0] sh;
    logic               sh_zero;
    logic               sh_small;
    logic               sh_is_w;
    logic               is_sub;
    logic [DATA_W:0]    sum;
    logic [DATA_W:0]    lsl_w;
    logic [DATA_W:0]    lsr_w;
    logic [DATA_W:0]    asr_w;

    assign sh       = b[SHAMT_W-1:0];
    assign sh_zero  = (sh == '0);
    assign sh_small = (sh < SHAMT_W'(DATA_W));
    assign sh_is_w  = (sh == SHAMT_W'(DATA_W));
    assign is_sub   = (op == CMD_SUB) || (op == CMD_SUBS);

    // One adder for add and subtract; carry out is not-borrow on subtract
    assign sum = {1'b0, a} + {1'b0, (is_sub ? ~b : b)} + {{DATA_W{1'b0}}, is_sub};

    // Extra bit catches the last bit shifted out
    assign lsl_w = {1'b0, a} << sh[4:0];
    assign lsr_w = {a, 1'b0} >> sh[4:0];
    assign asr_w = $unsigned($signed({a, 1'b0}) >>> sh[4:0]);

    always_comb
    begin
        result    = a;
        flags_out = flags_in;
        case (op)
            CMD_ADD, CMD_SUB:
            begin
                result = sum[DATA_W-1:0];
            end
            CMD_ADDS, CMD_SUBS:
            begin
                result      = sum[DATA_W-1:0];
                flags_out.c = sum[DATA_W];
                flags_out.v = is_sub ? ((a[DATA_W-1] ^ b[DATA_W-1])
                                        & (a[DATA_W-1] ^ result[DATA_W-1]))
                                     : (~(a[DATA_W-1] ^ b[DATA_W-1])
                                        & (a[DATA_W-1] ^ result[DATA_W-1]));
            end
            CMD_MVN, CMD_MVNS:
            begin
                result = ~a;
            end
            CMD_AND, CMD_ANDS:
            begin
                result = a & b;
            end
            CMD_ORR, CMD_ORRS:
            begin
                result = a | b;
            end
            CMD_EOR, CMD_EORS:
            begin
                result = a ^ b;
            end
            CMD_LSL:
            begin
                if (sh_zero)
                begin
                    result = a;
                end
                else if (sh_small)
                begin
                    result      = lsl_w[DATA_W-1:0];
                    flags_out.c = lsl_w[DATA_W];
                end
                else
                begin
                    result      = '0;
                    flags_out.c = sh_is_w && a[0];
                end
            end
            CMD_LSR:
            begin
                if (sh_zero)
                begin
                    result = a;
                end
                else if (sh_small)
                begin
                    result      = lsr_w[DATA_W:1];
                    flags_out.c = lsr_w[0];
                end
                else
                begin
                    result      = '0;
                    flags_out.c = sh_is_w && a[DATA_W-1];
                end
            end
            CMD_ASR:
            begin
                if (sh_zero)
                begin
                    result = a;
                end
                else if (sh_small)
                begin
                    result      = asr_w[DATA_W:1];
                    flags_out.c = asr_w[0];
                end
                else
                begin
                    result      = {DATA_W{a[DATA_W-1]}};
                    flags_out.c = a[DATA_W-1];
                end
            end
            CMD_MOV:
            begin
                result = a;
            end
            default:
            begin
                result = a;
            end
        endcase

        // N and Z follow the result on every flag-setting op
        case (op)
            CMD_ADDS, CMD_SUBS, CMD_ANDS, CMD_EORS, CMD_MVNS, CMD_ORRS,
            CMD_LSL, CMD_LSR, CMD_ASR:
            begin
                flags_out.n = result[DATA_W-1];
                flags_out.z = (result == '0);
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== hw/rtl/register_alu_with_flags.sv =====
// Top level of the register ALU with NZCV flags.
// Executes one decoded ALU instruction per request beat against an 8-entry,
// 32-bit register file and a four-bit NZCV flag register, and returns one
// response beat per request holding the value written and the flags after the
// instruction. Throughput is one instruction per cycle when the response side
// does not stall. The register file sits in a synchronous memory whose read
// is launched on the accepting edge, so the operand read comes first and
// execute and write-back into the response register follow; a result written
// back on the same edge that a following instruction reads is bypassed to it,
// so back-to-back dependent instructions see current values. The flags live
// in a flip-flop register and are read and updated in the execute cycle.
// Registers start at zero after reset through per-entry valid bits, so no
// clearing pass is needed. The response register decouples the two sides:
// req_stall rises only when an instruction waits in execute and the response
// register is full and stalled.
module register_alu_with_flags
    import raf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_beat_t req_data,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_beat_t rsp_data
);

    // Execute stage
    logic      ex_valid_reg;
    logic      ex_valid_next;
    req_beat_t ex_req_reg;

    // Response register
    logic      rsp_valid_reg;
    logic      rsp_valid_next;
    rsp_beat_t rsp_data_reg;

    flags_t    flags_reg;

    logic              req_fire;
    logic              ex_go;
    rf_rd_t            rf_rd;
    rf_wr_t            rf_wr;
    logic [DATA_W-1:0] rf_data_a;
    logic [DATA_W-1:0] rf_data_b;
    logic [DATA_W-1:0] opnd_a;
    logic [DATA_W-1:0] opnd_b;
    logic [DATA_W-1:0] alu_result;
    flags_t            alu_flags;

    // Handshake: execute retires whenever the response register can take it
    assign ex_go     = ex_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = ex_valid_reg && rsp_valid_reg && rsp_stall;
    assign req_fire  = req_valid && !req_stall;

    always_comb
    begin
        ex_valid_next = ex_valid_reg;
        if (req_fire)
        begin
            ex_valid_next = 1'b1;
        end
        else if (ex_go)
        begin
            ex_valid_next = 1'b0;
        end

        rsp_valid_next = rsp_valid_reg;
        if (ex_go)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Operand read launches on the accepting beat
    assign rf_rd.en     = req_fire;
    assign rf_rd.addr_a = req_data.first_reg;
    assign rf_rd.addr_b = req_data.second_reg;

    // Write back on retire; this edge is also bypassed to a reader
    assign rf_wr.en   = ex_go;
    assign rf_wr.addr = ex_req_reg.dest_reg;
    assign rf_wr.data = alu_result;

    raf_regfile u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd        (rf_rd),
        .wr        (rf_wr),
        .rd_data_a (rf_data_a),
        .rd_data_b (rf_data_b)
    );

    assign opnd_a = ex_req_reg.first_is_imm  ? ex_req_reg.first_imm  : rf_data_a;
    assign opnd_b = ex_req_reg.second_is_imm ? ex_req_reg.second_imm : rf_data_b;

    raf_alu u_alu (
        .op        (ex_req_reg.cmd),
        .a         (opnd_a),
        .b         (opnd_b),
        .flags_in  (flags_reg),
        .result    (alu_result),
        .flags_out (alu_flags)
    );

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end
        else
        begin
            ex_valid_reg  <= ex_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (ex_go)
            begin
                flags_reg <= alu_flags;
            end
        end
    end

    // Payload: hold the instruction in execute, load the response on retire
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            ex_req_reg <= req_data;
        end
        if (ex_go)
        begin
            rsp_data_reg.written_value <= alu_result;
            rsp_data_reg.flag_neg      <= alu_flags.n;
            rsp_data_reg.flag_zero     <= alu_flags.z;
            rsp_data_reg.flag_carry    <= alu_flags.c;
            rsp_data_reg.flag_over     <= alu_flags.v;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

// ===== hw/rtl/raf_checker.sv =====
// Port-level checker for the register ALU with flags, and its bind.
module raf_checker
    import raf_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_stall,
    input req_beat_t req_data,
    input logic      rsp_valid,
    input logic      rsp_stall,
    input rsp_beat_t rsp_data
);

    // A stalled response beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
    else $error("response beat changed while stalled");

    // Requests back up only behind a stalled, full response register
    assert property (@(posedge clk) disable iff (!rst_n)
        !(rsp_valid && rsp_stall) |-> !req_stall)
    else $error("request stalled with response side free");

    // An accepted beat reaches the response register when the response side does not hold it
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) ##1 (!rsp_valid || !rsp_stall) |=> rsp_valid)
    else $error("response beat missing after accepted request");

    // MOV of an immediate returns that immediate
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && (req_data.cmd == CMD_MOV) && req_data.first_is_imm)
        ##1 (!rsp_valid || !rsp_stall)
        |=> rsp_data.written_value == $past(req_data.first_imm, 2))
    else $error("MOV immediate returned wrong value");

endmodule

bind register_alu_with_flags raf_checker u_raf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
);
